FILE: rtl/fbwt_pkg.sv
// ----------------------------------------------------------------------------
// fbwt_pkg
// Shared types, codes and default sizes of the flash block wear table.
// ----------------------------------------------------------------------------
package fbwt_pkg;

    // default sizes of the table
    localparam int DEF_BLOCKS_PER_PLANE = 256;
    localparam int DEF_PLANES           = 4;
    localparam int DEF_ERASE_COUNT_BITS = 16;

    // fixed field widths
    localparam int OPCODE_BITS = 3;
    localparam int PLANE_BITS  = 2;
    localparam int BLOCK_BITS  = 8;
    localparam int SPREAD_BITS = 16;
    localparam int STATUS_BITS = 2;

    // outstanding program and read counters
    localparam int COUNT_BITS = 8;

    // activity word: program count, read count, collection mark
    localparam int ACT_BITS = 2 * COUNT_BITS + 1;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_QUERY      = 3'd0,
        OP_ERASE      = 3'd1,
        OP_PROG_ISSUE = 3'd2,
        OP_PROG_DONE  = 3'd3,
        OP_READ_ISSUE = 3'd4,
        OP_READ_DONE  = 3'd5,
        OP_GC_START   = 3'd6,
        OP_GC_FINISH  = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_CLAMPED   = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] prog_cnt;
        logic [COUNT_BITS-1:0] read_cnt;
        logic                  mark;
    } act_word_t;

endpackage

FILE: rtl/fbwt_ram.sv
// ----------------------------------------------------------------------------
// fbwt_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module fbwt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/fbwt_scan.sv
// ----------------------------------------------------------------------------
// fbwt_scan
// Walks the erase counts of one plane, one block a cycle, and keeps the
// running minimum, maximum and the first block holding the minimum.
// ----------------------------------------------------------------------------
module fbwt_scan #(
    parameter int BLOCKS_PER_PLANE = 256,
    parameter int ADDR_BITS        = 10,
    parameter int ERASE_COUNT_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [ADDR_BITS-1:0]                  base,
    output logic                                  rd_en,
    output logic [ADDR_BITS-1:0]                  rd_addr,
    input  logic [ERASE_COUNT_BITS-1:0]           rd_data,
    output logic                                  done,
    output logic [ERASE_COUNT_BITS-1:0]           min_cnt,
    output logic [ERASE_COUNT_BITS-1:0]           max_cnt,
    output logic [$clog2(BLOCKS_PER_PLANE)-1:0]   min_block
);

    localparam int BW = $clog2(BLOCKS_PER_PLANE);
    localparam logic [BW-1:0] LAST_BLOCK = BW'(BLOCKS_PER_PLANE - 1);

    logic                        busy_reg,  busy_next;
    logic [BW-1:0]               issue_reg, issue_next;
    logic                        dvalid_reg, dvalid_next;
    logic                        dlast_reg,  dlast_next;
    logic [BW-1:0]               didx_reg,   didx_next;
    logic                        done_reg,   done_next;
    logic [ERASE_COUNT_BITS-1:0] min_reg,    min_next;
    logic [ERASE_COUNT_BITS-1:0] max_reg,    max_next;
    logic [BW-1:0]               cold_reg,   cold_next;

    // read issue toward the erase count memory
    assign rd_en   = busy_reg;
    assign rd_addr = ADDR_BITS'(base + ADDR_BITS'(issue_reg));

    always_comb
    begin
        busy_next   = busy_reg;
        issue_next  = issue_reg;
        dvalid_next = busy_reg;
        dlast_next  = busy_reg && (issue_reg == LAST_BLOCK);
        didx_next   = issue_reg;
        done_next   = dvalid_reg && dlast_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        cold_next   = cold_reg;

        // address counter
        if (start)
        begin
            busy_next  = 1'b1;
            issue_next = '0;
        end
        else if (busy_reg)
        begin
            issue_next = BW'(issue_reg + 1'b1);
            if (issue_reg == LAST_BLOCK)
            begin
                busy_next = 1'b0;
            end
        end

        // min / max tracking on returning data
        if (dvalid_reg)
        begin
            if (didx_reg == '0)
            begin
                min_next  = rd_data;
                max_next  = rd_data;
                cold_next = '0;
            end
            else
            begin
                if (rd_data > max_reg)
                begin
                    max_next = rd_data;
                end
                if (rd_data < min_reg)
                begin
                    min_next  = rd_data;
                    cold_next = didx_reg;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            dvalid_reg <= 1'b0;
            dlast_reg  <= 1'b0;
            done_reg   <= 1'b0;
            issue_reg  <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            dvalid_reg <= dvalid_next;
            dlast_reg  <= dlast_next;
            done_reg   <= done_next;
            issue_reg  <= issue_next;
        end
    end

    // running results
    always_ff @(posedge clk)
    begin
        didx_reg <= didx_next;
        min_reg  <= min_next;
        max_reg  <= max_next;
        cold_reg <= cold_next;
    end

    assign done      = done_reg;
    assign min_cnt   = min_reg;
    assign max_cnt   = max_reg;
    assign min_block = cold_reg;

endmodule

FILE: rtl/flash_block_wear_table.sv
// ----------------------------------------------------------------------------
// flash_block_wear_table
// Per-block erase count and activity record for a set of flash planes, with
// a plane-wide erase spread and coldest block reported per in-range event.
// ----------------------------------------------------------------------------
//
//  channel | signals                                         | role
//  --------+-------------------------------------------------+-----------------
//  in      | in_valid, in_ready, opcode, plane_index,        | event transfer
//          | block_index                                     |
//  out     | out_valid, out_ready, erase_spread,             | result transfer
//          | coldest_block, gc_allowed, gc_active,           |
//          | program_pending, status                         |
//
//  An in-range event passes through S_MODIFY, the plane scan and S_FINISH into
//  the output register, the plane scan reading one erase count per cycle from
//  the erase count memory; the next event can follow once the result is loaded.
//  An out-of-range event goes from S_IDLE straight to S_FINISH, skips the scan
//  and leaves the memories untouched.
//  After reset a clearing pass writes PLANES * BLOCKS_PER_PLANE entries, one
//  a cycle, with in_ready low.
//  One event is in flight at a time; the next event is taken while the last
//  result still waits in the output register. A stalled output holds the
//  finished result until the output register frees up.
// ----------------------------------------------------------------------------
module flash_block_wear_table #(
    parameter int BLOCKS_PER_PLANE = fbwt_pkg::DEF_BLOCKS_PER_PLANE,
    parameter int PLANES           = fbwt_pkg::DEF_PLANES,
    parameter int ERASE_COUNT_BITS = fbwt_pkg::DEF_ERASE_COUNT_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [fbwt_pkg::OPCODE_BITS-1:0] opcode,
    input  logic [fbwt_pkg::PLANE_BITS-1:0]  plane_index,
    input  logic [fbwt_pkg::BLOCK_BITS-1:0]  block_index,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [fbwt_pkg::SPREAD_BITS-1:0] erase_spread,
    output logic [fbwt_pkg::BLOCK_BITS-1:0]  coldest_block,
    output logic                             gc_allowed,
    output logic                             gc_active,
    output logic                             program_pending,
    output logic [fbwt_pkg::STATUS_BITS-1:0] status
);

    import fbwt_pkg::*;

    localparam int TOTAL = PLANES * BLOCKS_PER_PLANE;
    localparam int AW    = $clog2(TOTAL);
    localparam int BW    = $clog2(BLOCKS_PER_PLANE);
    localparam logic [AW-1:0] LAST_ENTRY = AW'(TOTAL - 1);
    localparam logic [ERASE_COUNT_BITS-1:0] ERASE_TOP = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_MODIFY = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t                  state_reg,   state_next;
    logic [AW-1:0]           clr_reg,     clr_next;
    opcode_t                 op_reg,      op_next;
    logic [AW-1:0]           idx_reg,     idx_next;
    logic [AW-1:0]           base_reg,    base_next;
    logic [SPREAD_BITS-1:0]  rspread_reg, rspread_next;
    logic [BLOCK_BITS-1:0]   rcold_reg,   rcold_next;
    logic                    rallow_reg,  rallow_next;
    logic                    ractive_reg, ractive_next;
    logic                    rpend_reg,   rpend_next;
    status_t                 rstat_reg,   rstat_next;
    logic                    ovalid_reg,  ovalid_next;
    logic [SPREAD_BITS-1:0]  ospread_reg, ospread_next;
    logic [BLOCK_BITS-1:0]   ocold_reg,   ocold_next;
    logic                    oallow_reg,  oallow_next;
    logic                    oactive_reg, oactive_next;
    logic                    opend_reg,   opend_next;
    status_t                 ostat_reg,   ostat_next;

    // memory ports
    logic                        ers_we, ers_re, act_we, act_re;
    logic [AW-1:0]               ers_waddr, ers_raddr, act_waddr;
    logic [ERASE_COUNT_BITS-1:0] ers_wdata, ers_rdata;
    logic [ACT_BITS-1:0]         act_wdata, act_rdata;
    act_word_t                   act_cur, act_new;

    // scan unit
    logic                        scan_start, scan_rd_en, scan_done;
    logic [AW-1:0]               scan_rd_addr;
    logic [ERASE_COUNT_BITS-1:0] scan_min, scan_max, spread_full;
    logic [BW-1:0]               scan_cold;

    // event decode
    logic          in_range, accept;
    logic [AW-1:0] in_idx, in_base;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_range = (32'(plane_index) < PLANES) && (32'(block_index) < BLOCKS_PER_PLANE);
    assign in_base  = AW'(32'(plane_index) * BLOCKS_PER_PLANE);
    assign in_idx   = AW'(32'(in_base) + 32'(block_index));

    assign act_cur     = act_word_t'(act_rdata);
    assign spread_full = ERASE_COUNT_BITS'(scan_max - scan_min);

    // erase count read port: scan walk or addressed block
    assign ers_re    = (accept && in_range) || scan_rd_en;
    assign ers_raddr = scan_rd_en ? scan_rd_addr : in_idx;
    assign act_re    = accept && in_range;

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        base_next    = base_reg;
        rspread_next = rspread_reg;
        rcold_next   = rcold_reg;
        rallow_next  = rallow_reg;
        ractive_next = ractive_reg;
        rpend_next   = rpend_reg;
        rstat_next   = rstat_reg;
        ovalid_next  = ovalid_reg;
        ospread_next = ospread_reg;
        ocold_next   = ocold_reg;
        oallow_next  = oallow_reg;
        oactive_next = oactive_reg;
        opend_next   = opend_reg;
        ostat_next   = ostat_reg;
        ers_we       = 1'b0;
        ers_waddr    = idx_reg;
        ers_wdata    = ERASE_COUNT_BITS'(act_rdata[0]);
        act_we       = 1'b0;
        act_waddr    = idx_reg;
        act_new      = act_cur;
        act_wdata    = ACT_BITS'(act_new);
        scan_start   = 1'b0;

        // output register drains on transfer
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            // zero both memories after reset
            S_CLEAR:
            begin
                ers_we    = 1'b1;
                act_we    = 1'b1;
                ers_waddr = clr_reg;
                act_waddr = clr_reg;
                ers_wdata = '0;
                act_wdata = '0;
                if (clr_reg == LAST_ENTRY)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = AW'(clr_reg + 1'b1);
                end
            end

            // take an event, start the reads of an in-range one
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next   = opcode_t'(opcode);
                    idx_next  = in_idx;
                    base_next = in_base;
                    if (in_range)
                    begin
                        state_next = S_MODIFY;
                    end
                    else
                    begin
                        rspread_next = '0;
                        rcold_next   = '0;
                        rallow_next  = 1'b0;
                        ractive_next = 1'b0;
                        rpend_next   = 1'b0;
                        rstat_next   = ST_OK;
                        state_next   = S_FINISH;
                    end
                end
            end

            // update the addressed entry and write it back
            S_MODIFY:
            begin
                rstat_next = ST_OK;
                ers_wdata  = ERASE_COUNT_BITS'(ers_rdata + 1'b1);
                case (op_reg)
                    OP_QUERY:
                    begin
                    end
                    OP_ERASE:
                    begin
                        if (ers_rdata == ERASE_TOP)
                        begin
                            rstat_next = ST_SATURATED;
                        end
                        else
                        begin
                            ers_we = 1'b1;
                        end
                    end
                    OP_PROG_ISSUE:
                    begin
                        if (act_cur.prog_cnt == COUNT_TOP)
                        begin
                            rstat_next = ST_SATURATED;
                        end
                        else
                        begin
                            act_new.prog_cnt = COUNT_BITS'(act_cur.prog_cnt + 1'b1);
                        end
                    end
                    OP_PROG_DONE:
                    begin
                        if (act_cur.prog_cnt == '0)
                        begin
                            rstat_next = ST_CLAMPED;
                        end
                        else
                        begin
                            act_new.prog_cnt = COUNT_BITS'(act_cur.prog_cnt - 1'b1);
                        end
                    end
                    OP_READ_ISSUE:
                    begin
                        if (act_cur.read_cnt == COUNT_TOP)
                        begin
                            rstat_next = ST_SATURATED;
                        end
                        else
                        begin
                            act_new.read_cnt = COUNT_BITS'(act_cur.read_cnt + 1'b1);
                        end
                    end
                    OP_READ_DONE:
                    begin
                        if (act_cur.read_cnt == '0)
                        begin
                            rstat_next = ST_CLAMPED;
                        end
                        else
                        begin
                            act_new.read_cnt = COUNT_BITS'(act_cur.read_cnt - 1'b1);
                        end
                    end
                    OP_GC_START:
                    begin
                        act_new.mark = 1'b1;
                    end
                    OP_GC_FINISH:
                    begin
                        act_new.mark = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
                act_we       = 1'b1;
                act_wdata    = ACT_BITS'(act_new);
                rallow_next  = (act_new.prog_cnt == '0) && (act_new.read_cnt == '0);
                ractive_next = act_new.mark;
                rpend_next   = (act_new.prog_cnt != '0);
                scan_start   = 1'b1;
                state_next   = S_SCAN;
            end

            // wait for the plane walk
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (32'(spread_full) > 32'(16'hFFFF))
                    begin
                        rspread_next = '1;
                    end
                    else
                    begin
                        rspread_next = SPREAD_BITS'(spread_full);
                    end
                    rcold_next = BLOCK_BITS'(scan_cold);
                    state_next = S_FINISH;
                end
            end

            // hand the result to the output register
            S_FINISH:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next  = 1'b1;
                    ospread_next = rspread_reg;
                    ocold_next   = rcold_reg;
                    oallow_next  = rallow_reg;
                    oactive_next = ractive_reg;
                    opend_next   = rpend_reg;
                    ostat_next   = rstat_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // event and result payload
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        base_reg    <= base_next;
        rspread_reg <= rspread_next;
        rcold_reg   <= rcold_next;
        rallow_reg  <= rallow_next;
        ractive_reg <= ractive_next;
        rpend_reg   <= rpend_next;
        rstat_reg   <= rstat_next;
        ospread_reg <= ospread_next;
        ocold_reg   <= ocold_next;
        oallow_reg  <= oallow_next;
        oactive_reg <= oactive_next;
        opend_reg   <= opend_next;
        ostat_reg   <= ostat_next;
    end

    // erase count memory
    fbwt_ram #(
        .WIDTH (ERASE_COUNT_BITS),
        .DEPTH (TOTAL)
    ) u_ers_ram (
        .clk   (clk),
        .we    (ers_we),
        .waddr (ers_waddr),
        .wdata (ers_wdata),
        .re    (ers_re),
        .raddr (ers_raddr),
        .rdata (ers_rdata)
    );

    // program / read / collection memory
    fbwt_ram #(
        .WIDTH (ACT_BITS),
        .DEPTH (TOTAL)
    ) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .re    (act_re),
        .raddr (in_idx),
        .rdata (act_rdata)
    );

    // plane min / max walk
    fbwt_scan #(
        .BLOCKS_PER_PLANE (BLOCKS_PER_PLANE),
        .ADDR_BITS        (AW),
        .ERASE_COUNT_BITS (ERASE_COUNT_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (scan_start),
        .base      (base_reg),
        .rd_en     (scan_rd_en),
        .rd_addr   (scan_rd_addr),
        .rd_data   (ers_rdata),
        .done      (scan_done),
        .min_cnt   (scan_min),
        .max_cnt   (scan_max),
        .min_block (scan_cold)
    );

    // result ports
    assign out_valid       = ovalid_reg;
    assign erase_spread    = ospread_reg;
    assign coldest_block   = ocold_reg;
    assign gc_allowed      = oallow_reg;
    assign gc_active       = oactive_reg;
    assign program_pending = opend_reg;
    assign status          = ostat_reg;

endmodule

FILE: rtl/fbwt_checker.sv
// ----------------------------------------------------------------------------
// fbwt_checker
// Port-level checks of the flash block wear table, bound to the top level.
// ----------------------------------------------------------------------------
module fbwt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [fbwt_pkg::OPCODE_BITS-1:0] opcode,
    input logic [fbwt_pkg::PLANE_BITS-1:0]  plane_index,
    input logic [fbwt_pkg::BLOCK_BITS-1:0]  block_index,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [fbwt_pkg::SPREAD_BITS-1:0] erase_spread,
    input logic [fbwt_pkg::BLOCK_BITS-1:0]  coldest_block,
    input logic                             gc_allowed,
    input logic                             gc_active,
    input logic                             program_pending,
    input logic [fbwt_pkg::STATUS_BITS-1:0] status
);

    import fbwt_pkg::*;

    // a waiting event keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(opcode)
            && $stable(plane_index) && $stable(block_index))
        else $error("waiting event changed");

    // a stalled result keeps its spread, coldest block, status and collection flag
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(erase_spread)
            && $stable(coldest_block) && $stable(status) && $stable(gc_active))
        else $error("stalled result changed");

    // status carries only defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_CLAMPED)
            || (status == ST_SATURATED))
        else $error("undefined status code");

    // a pending program forbids collection
    a_gc_vs_prog: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && program_pending |-> !gc_allowed)
        else $error("collection allowed with a program pending");

    // one event in flight: no transfer right after a transfer
    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("event taken while the previous one is in flight");

endmodule

bind flash_block_wear_table fbwt_checker u_fbwt_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .plane_index     (plane_index),
    .block_index     (block_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .erase_spread    (erase_spread),
    .coldest_block   (coldest_block),
    .gc_allowed      (gc_allowed),
    .gc_active       (gc_active),
    .program_pending (program_pending),
    .status          (status)
);
